### rtl/hpe_pkg.sv
package hpe_pkg;

  // default number of cells, one per coefficient
  localparam int unsigned MAX_TERMS_DEF = 16;

  // field widths
  localparam int unsigned CoefW  = 32;
  localparam int unsigned AccW   = 48;
  localparam int unsigned IndexW = 4;
  localparam int unsigned TermsW = 5;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // terms in use after reset
  localparam logic [TermsW-1:0] TERMS_RESET = TermsW'(1);

  // Q32.16 accumulator limits
  localparam logic signed [AccW-1:0] ACC_MAX = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] ACC_MIN = {1'b1, {(AccW-1){1'b0}}};

  // input transaction
  typedef struct packed {
    logic                     req_type;
    logic [IndexW-1:0]        coef_index;
    logic signed [CoefW-1:0]  coef_value;
    logic signed [CoefW-1:0]  x_value;
    logic                     last_point;
  } req_t;

  // output transaction
  typedef struct packed {
    logic signed [AccW-1:0] y_value;
    logic                   saturated;
    logic                   last_out;
  } rsp_t;

  // item between cells; x carries the coefficient for load items
  typedef struct packed {
    logic                    valid;
    logic                    eval;
    logic [IndexW-1:0]       index;
    logic signed [CoefW-1:0] x;
    logic signed [AccW-1:0]  acc;
    logic                    sat;
    logic                    last;
  } pipe_t;

  // item inside a cell, after the partial products
  typedef struct packed {
    logic                    valid;
    logic                    eval;
    logic [IndexW-1:0]       index;
    logic signed [CoefW-1:0] x;
    logic signed [55:0]      p_hi;
    logic signed [56:0]      p_lo;
    logic                    sat;
    logic                    last;
  } mid_t;

endpackage

### rtl/hpe_cell.sv
module hpe_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [hpe_pkg::TermsW-1:0]   terms_i,
  input  hpe_pkg::pipe_t               pipe_i,
  output hpe_pkg::pipe_t               pipe_o
);
  import hpe_pkg::*;

  mid_t                    mid_d, mid_q;
  pipe_t                   pipe_d, pipe_q;
  logic signed [CoefW-1:0] coef_d, coef_q;

  logic signed [23:0]      acc_hi;
  logic signed [24:0]      acc_lo;
  logic signed [79:0]      prod;
  logic signed [63:0]      prod_shr;
  logic signed [CoefW-1:0] coef_use;
  logic signed [64:0]      sum;

  // first half: two 24x32 partial products of acc * x
  always_comb begin
    acc_hi       = pipe_i.acc[47:24];
    acc_lo       = {1'b0, pipe_i.acc[23:0]};
    mid_d.valid  = pipe_i.valid;
    mid_d.eval   = pipe_i.eval;
    mid_d.index  = pipe_i.index;
    mid_d.x      = pipe_i.x;
    mid_d.p_hi   = 56'(acc_hi * pipe_i.x);
    mid_d.p_lo   = 57'(acc_lo * pipe_i.x);
    mid_d.sat    = pipe_i.sat;
    mid_d.last   = pipe_i.last;
  end

  // second half: join products, floor shift, add coefficient, clip
  always_comb begin
    prod     = (80'(mid_q.p_hi) <<< 24) + 80'(mid_q.p_lo);
    prod_shr = prod[79:16];
    coef_use = (32'(terms_i) > Idx) ? coef_q : '0;
    sum      = 65'(prod_shr) + 65'(coef_use);

    pipe_d.valid = mid_q.valid;
    pipe_d.eval  = mid_q.eval;
    pipe_d.index = mid_q.index;
    pipe_d.x     = mid_q.x;
    pipe_d.last  = mid_q.last;
    pipe_d.sat   = mid_q.sat;
    if (sum > 65'(ACC_MAX)) begin
      pipe_d.acc = ACC_MAX;
      pipe_d.sat = 1'b1;
    end else if (sum < 65'(ACC_MIN)) begin
      pipe_d.acc = ACC_MIN;
      pipe_d.sat = 1'b1;
    end else begin
      pipe_d.acc = sum[AccW-1:0];
    end
  end

  // coefficient update when a load transaction for this power passes
  always_comb begin
    coef_d = coef_q;
    if (mid_q.valid && !mid_q.eval && (32'(mid_q.index) == Idx)) begin
      coef_d = mid_q.x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= '0;
      pipe_q <= '0;
      coef_q <= '0;
    end else if (en_i) begin
      mid_q  <= mid_d;
      pipe_q <= pipe_d;
      coef_q <= coef_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule

### rtl/horner_polynomial_evaluator.sv
// Horner polynomial evaluator
// Input channel (in_valid_i / in_ready_o / in_data_i) takes two kinds of
// transaction: a load writes one Q16.16 coefficient at coef_index, an evaluate
// returns y = sum c[i]*x^i over the first terms_in_use coefficients as a
// saturated Q32.16 value, with a flag if any step clipped and last_point
// copied to last_out. Loads give no output transaction.
// terms_in_use is written through cfg_we_i / cfg_wdata_i. The user writes it
// only while the block is idle; the block does not enforce it. Values above
// MaxTerms act as MaxTerms, zero gives y = 0. The datapath is a row of
// MaxTerms cells, one per coefficient, highest power first. Each cell holds
// its coefficient and does one Horner step in two register stages (partial
// products, then sum and clip). While the output is not stalled, one
// transaction of either kind is accepted every cycle; loads travel down the
// row in order with evaluations, so each evaluation sees exactly the loads
// before it. Reset clears every coefficient to zero, sets terms_in_use to
// one and empties the row. When the receiver stalls, the whole row holds and
// in_ready_o drops until the waiting output transaction is taken.
module horner_polynomial_evaluator #(
  parameter int unsigned MaxTerms = hpe_pkg::MAX_TERMS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  hpe_pkg::req_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hpe_pkg::rsp_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [hpe_pkg::TermsW-1:0] cfg_wdata_i
);
  import hpe_pkg::*;

  logic              en;
  logic [TermsW-1:0] terms_q;
  pipe_t             chain [MaxTerms+1];
  logic              out_valid_q;
  rsp_t              out_q;

  // whole row advances when the output slot is free or being emptied
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      terms_q <= TERMS_RESET;
    end else if (cfg_we_i) begin
      terms_q <= cfg_wdata_i;
    end
  end

  // transaction entering the row, accumulator starts at zero
  always_comb begin
    chain[0].valid = in_valid_i && en;
    chain[0].eval  = (in_data_i.req_type == REQ_EVAL);
    chain[0].index = in_data_i.coef_index;
    chain[0].x     = (in_data_i.req_type == REQ_EVAL) ? in_data_i.x_value
                                                       : in_data_i.coef_value;
    chain[0].acc   = '0;
    chain[0].sat   = 1'b0;
    chain[0].last  = in_data_i.last_point;
  end

  // row of cells, highest power first
  for (genvar k = 0; k < MaxTerms; k++) begin : g_cell
    hpe_cell #(
      .Idx (MaxTerms - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .terms_i (terms_q),
      .pipe_i  (chain[k]),
      .pipe_o  (chain[k+1])
    );
  end

  // output register, evaluations only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[MaxTerms].valid && chain[MaxTerms].eval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.y_value   <= chain[MaxTerms].acc;
      out_q.saturated <= chain[MaxTerms].sat;
      out_q.last_out  <= chain[MaxTerms].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/hpe_checker.sv
module hpe_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input hpe_pkg::req_t              in_data_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input hpe_pkg::rsp_t              out_data_o,
  input logic                       cfg_we_i,
  input logic [hpe_pkg::TermsW-1:0] cfg_wdata_i
);

  // no output transaction once reset has been seen at an edge
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // a stalled output transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // input is taken exactly when the output slot is free or draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output slot");

  // a stalled output blocks the input in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output still stalled");

endmodule

bind horner_polynomial_evaluator hpe_checker u_hpe_checker (.*);
